/* rtl/sbi_pkg.sv */
// ----------------------------------------------------------------------------
// sbi_pkg
// Types, constants and helpers shared by the segment/box intersection block.
// ----------------------------------------------------------------------------
package sbi_pkg;

    localparam int COORD_W = 32;
    localparam int D_W     = COORD_W + 1;
    localparam int DEN_W   = COORD_W + 2;
    localparam int T_BITS  = 24;
    localparam int P_W     = D_W + 1;
    localparam int C_W     = P_W + 1;
    localparam int M_W     = D_W + T_BITS + 1;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [D_W-1:0]     t_dist;
    typedef logic signed [P_W-1:0]     t_prod;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] start_z;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
        logic signed [COORD_W-1:0] end_z;
    } t_seg;

    typedef struct packed {
        logic hits_box;
        logic box_valid;
    } t_res;

    typedef struct packed {
        t_coord [2:0] lo;
        t_coord [2:0] hi;
    } t_box;

    // item as it leaves the classifier
    typedef struct packed {
        logic         known;
        logic         khit;
        logic         bvalid;
        t_coord [2:0] s;
        t_dist  [2:0] dl;
        t_dist  [5:0] d1;
        t_dist  [5:0] d2;
        logic   [5:0] act;
    } t_work;

    typedef struct packed {
        logic         known;
        logic         khit;
        logic         bvalid;
        t_coord [2:0] s;
        t_dist  [2:0] dl;
    } t_item;

    typedef struct packed {
        logic             act;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [T_BITS-1:0] q;
    } t_div;

    function automatic t_div div_step(input t_div x);
        t_div          y;
        logic [DEN_W:0] r2;
        y  = x;
        r2 = {x.rem, 1'b0};
        if (r2 >= {1'b0, x.den}) begin
            y.rem = DEN_W'(r2 - {1'b0, x.den});
            y.q   = {x.q[T_BITS-2:0], 1'b1};
        end else begin
            y.rem = r2[DEN_W-1:0];
            y.q   = {x.q[T_BITS-2:0], 1'b0};
        end
        return y;
    endfunction

endpackage

/* rtl/sbi_front.sv */
// ----------------------------------------------------------------------------
// sbi_front
// Classifies each segment (box check, early reject, start inside) and forms
// face distances; holds the words in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sbi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  sbi_pkg::t_seg i_seg,
    input  sbi_pkg::t_box i_box,
    input  logic          i_take,
    output logic          o_avail,
    output sbi_pkg::t_work o_work
);
    import sbi_pkg::*;

    t_work      w;
    t_work      r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push_ok, pop_ok;

    always_comb begin
        t_coord s [3];
        t_coord e [3];
        t_coord p;
        logic   rej, ins, val;
        s[0] = i_seg.start_x; s[1] = i_seg.start_y; s[2] = i_seg.start_z;
        e[0] = i_seg.end_x;   e[1] = i_seg.end_y;   e[2] = i_seg.end_z;
        rej = 1'b0;
        ins = 1'b1;
        val = 1'b1;
        w   = '0;
        for (int a = 0; a < 3; a++) begin
            if ($signed(i_box.lo[a]) > $signed(i_box.hi[a])) val = 1'b0;
            if (s[a] < $signed(i_box.lo[a]) && e[a] < $signed(i_box.lo[a])) rej = 1'b1;
            if (s[a] > $signed(i_box.hi[a]) && e[a] > $signed(i_box.hi[a])) rej = 1'b1;
            if (!(s[a] > $signed(i_box.lo[a]) && s[a] < $signed(i_box.hi[a]))) ins = 1'b0;
            w.s[a]  = s[a];
            w.dl[a] = D_W'({e[a][COORD_W-1], e[a]} - {s[a][COORD_W-1], s[a]});
        end
        for (int f = 0; f < 6; f++) begin
            p = (f < 3) ? i_box.lo[f % 3] : i_box.hi[f % 3];
            w.d1[f] = D_W'({s[f%3][COORD_W-1], s[f%3]} - {p[COORD_W-1], p});
            w.d2[f] = D_W'({e[f%3][COORD_W-1], e[f%3]} - {p[COORD_W-1], p});
            w.act[f] = ($signed(w.d1[f]) < 0 && $signed(w.d2[f]) > 0)
                    || ($signed(w.d1[f]) > 0 && $signed(w.d2[f]) < 0);
        end
        w.bvalid = val;
        w.known  = !val || rej || ins;
        w.khit   = val && !rej && ins;
    end

    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_work  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_take && o_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= !r_wp;
            if (pop_ok)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_mem[r_wp] <= w;
    end

endmodule

/* rtl/sbi_back.sv */
// ----------------------------------------------------------------------------
// sbi_back
// Six face lanes: bit-per-stage divider for t, one multiply stage, then the
// hit-point bounds check into a two-entry result queue.
// ----------------------------------------------------------------------------
module sbi_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    output logic           o_take,
    input  sbi_pkg::t_work i_work,
    input  sbi_pkg::t_box  i_box,
    output logic           o_empty,
    input  logic           i_pop,
    output sbi_pkg::t_res  o_res
);
    import sbi_pkg::*;

    logic  r_v  [T_BITS+1];
    t_item r_it [T_BITS+1];
    t_div  r_dv [T_BITS+1][6];

    logic        r_mv;
    t_item       r_mit;
    logic  [5:0] r_mact;
    t_prod       r_mp [6][2];

    t_res       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       en, push_ok, pop_ok;
    t_res       res;

    assign en     = !(r_mv && r_cnt == 2'd2);
    assign o_take = en && i_avail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= T_BITS; k++) r_v[k] <= 1'b0;
            r_mv <= 1'b0;
        end else if (en) begin
            r_v[0] <= i_avail;
            for (int k = 1; k <= T_BITS; k++) r_v[k] <= r_v[k-1];
            r_mv <= r_v[T_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        logic [D_W-1:0] n1, n2;
        if (en) begin
            r_it[0].known  <= i_work.known;
            r_it[0].khit   <= i_work.khit;
            r_it[0].bvalid <= i_work.bvalid;
            r_it[0].s      <= i_work.s;
            r_it[0].dl     <= i_work.dl;
            for (int f = 0; f < 6; f++) begin
                n1 = i_work.d1[f][D_W-1] ? D_W'(-i_work.d1[f]) : i_work.d1[f];
                n2 = i_work.d2[f][D_W-1] ? D_W'(-i_work.d2[f]) : i_work.d2[f];
                r_dv[0][f].act <= i_work.act[f];
                r_dv[0][f].rem <= DEN_W'(n1);
                r_dv[0][f].den <= DEN_W'(n1) + DEN_W'(n2);
                r_dv[0][f].q   <= '0;
            end
            for (int k = 1; k <= T_BITS; k++) begin
                r_it[k] <= r_it[k-1];
                for (int f = 0; f < 6; f++) r_dv[k][f] <= div_step(r_dv[k-1][f]);
            end
            r_mit <= r_it[T_BITS];
            for (int f = 0; f < 6; f++) begin
                r_mact[f] <= r_dv[T_BITS][f].act;
                for (int j = 0; j < 2; j++) begin
                    r_mp[f][j] <= P_W'((M_W'($signed(r_it[T_BITS].dl[(f % 3 + 1 + j) % 3]))
                        * M_W'($signed({1'b0, r_dv[T_BITS][f].q}))) >>> T_BITS);
                end
            end
        end
    end

    always_comb begin
        logic [5:0]             fh;
        logic                   ok;
        logic signed [C_W-1:0]  c;
        int                     b;
        for (int f = 0; f < 6; f++) begin
            ok = r_mact[f];
            for (int j = 0; j < 2; j++) begin
                b = (f % 3 + 1 + j) % 3;
                c = C_W'($signed(r_mit.s[b])) + C_W'(r_mp[f][j]);
                if (c < C_W'($signed(i_box.lo[b])) || c > C_W'($signed(i_box.hi[b])))
                    ok = 1'b0;
            end
            fh[f] = ok;
        end
        res.box_valid = r_mit.bvalid;
        res.hits_box  = r_mit.known ? r_mit.khit : (|fh);
    end

    assign push_ok = en && r_mv;
    assign pop_ok  = i_pop && !o_empty;
    assign o_empty = (r_cnt == 2'd0);
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) r_wp <= !r_wp;
            if (pop_ok)  r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(push_ok) - 2'(pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= res;
    end

endmodule

/* rtl/segment_box_intersect.sv */
// ----------------------------------------------------------------------------
// segment_box_intersect
// 3D segment versus axis-aligned box test, signed Q16.16, one word per cycle while the result queue has room.
//
//  channel   handshake              payload
//  input     i_push / o_full        i_seg  (start/end xyz)
//  result    o_empty / i_pop        o_res  (hits_box, box_valid)
//  config    i_cfg_valid/o_cfg_ready  i_cfg_index, i_cfg_data
//
// Result word reaches o_res through the front queue, the divider load plus 24
// divider stages per face lane, the multiply stage and the result queue; one
// word per cycle sustained while the result queue has room.
// Pipeline advances as a whole; it holds only while the result queue is full.
// Synchronous reset empties both queues and loads an invalid box.
// ----------------------------------------------------------------------------
module segment_box_intersect (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    output logic                       o_full,
    input  sbi_pkg::t_seg              i_seg,
    output logic                       o_empty,
    input  logic                       i_pop,
    output sbi_pkg::t_res              o_res,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [sbi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sbi_pkg::COORD_W-1:0]   i_cfg_data
);
    import sbi_pkg::*;

    t_box  r_box;
    t_work work;
    logic  avail, take;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box.lo[a] <= COORD_W'(65536);
                r_box.hi[a] <= -COORD_W'(65536);
            end
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_X: r_box.lo[0] <= i_cfg_data;
                CFG_MIN_Y: r_box.lo[1] <= i_cfg_data;
                CFG_MIN_Z: r_box.lo[2] <= i_cfg_data;
                CFG_MAX_X: r_box.hi[0] <= i_cfg_data;
                CFG_MAX_Y: r_box.hi[1] <= i_cfg_data;
                CFG_MAX_Z: r_box.hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    sbi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_seg   (i_seg),
        .i_box   (r_box),
        .i_take  (take),
        .o_avail (avail),
        .o_work  (work)
    );

    sbi_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .o_take  (take),
        .i_work  (work),
        .i_box   (r_box),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (o_res)
    );

    a_hit_needs_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !(o_res.hits_box && !o_res.box_valid))
        else $error("hit reported for invalid box");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("queues not empty after reset");

    a_take_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> avail)
        else $error("back end took from empty queue");

endmodule

/* bench/tb_segment_box_intersect.sv */
// ----------------------------------------------------------------------------
// tb_segment_box_intersect
// Streams segment words through the segment/box intersection block under a
// series of box settings (reset box, ordinary, full range, point and invalid
// boxes, random boxes). Each accepted word is predicted in the bench and
// every result word is checked field by field, with random idling on both
// sides, a long result stall and a sender pause.
// ----------------------------------------------------------------------------
module tb_segment_box_intersect;
    timeunit 1ns;
    timeprecision 1ps;
    import sbi_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
    localparam longint ONE = 65536;
    localparam longint CMIN = -64'sd2147483648;
    localparam longint CMAX = 64'sd2147483647;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic o_full;
    t_seg i_seg = '0;
    logic o_empty;
    logic i_pop = 1'b0;
    t_res o_res;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0] i_cfg_data = '0;

    segment_box_intersect dut (.*);

    always #5 i_clk = ~i_clk;

    longint box_lo[3];
    longint box_hi[3];
    t_seg seg_pending[$];
    t_res hit_expected[$];
    bit word_taken = 1'b0;
    bit calm = 1'b0;
    bit send_hold = 1'b0;
    bit rx_hold = 1'b0;
    int errors = 0;
    int n_words = 0;
    int n_hits = 0;
    int n_phases = 0;

    function automatic bit face_crossed(input longint s[3], input longint e[3],
                                        input int a, input longint plane);
        longint d1, d2, num, den, t, c;
        d1 = s[a] - plane;
        d2 = e[a] - plane;
        if (!((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0)))
            return 1'b0;
        num = d1 < 0 ? -d1 : d1;
        den = num + (d2 < 0 ? -d2 : d2);
        t = (num << T_BITS) / den;
        for (int b = 0; b < 3; b++) begin
            if (b != a) begin
                c = s[b] + (((e[b] - s[b]) * t) >>> T_BITS);
                if (c < box_lo[b] || c > box_hi[b])
                    return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_res predict_hit(input t_seg sg);
        longint s[3], e[3];
        bit start_in;
        t_res r;
        s[0] = sg.start_x; s[1] = sg.start_y; s[2] = sg.start_z;
        e[0] = sg.end_x;   e[1] = sg.end_y;   e[2] = sg.end_z;
        r = '0;
        r.box_valid = 1'b1;
        for (int a = 0; a < 3; a++)
            if (box_lo[a] > box_hi[a])
                r.box_valid = 1'b0;
        if (!r.box_valid)
            return r;
        for (int a = 0; a < 3; a++) begin
            if ((s[a] < box_lo[a] && e[a] < box_lo[a]) ||
                (s[a] > box_hi[a] && e[a] > box_hi[a]))
                return r;
        end
        start_in = 1'b1;
        for (int a = 0; a < 3; a++)
            if (!(s[a] > box_lo[a] && s[a] < box_hi[a]))
                start_in = 1'b0;
        if (start_in) begin
            r.hits_box = 1'b1;
            return r;
        end
        for (int f = 0; f < 6; f++) begin
            if (face_crossed(s, e, f % 3, f < 3 ? box_lo[f % 3] : box_hi[f % 3])) begin
                r.hits_box = 1'b1;
                return r;
            end
        end
        return r;
    endfunction

    function automatic longint rnd_between(input longint a, input longint b);
        longint unsigned r;
        r = {$urandom, $urandom};
        return a + longint'(r % longint'(b - a + 1));
    endfunction

    function automatic longint clamp(input longint v);
        return v < CMIN ? CMIN : (v > CMAX ? CMAX : v);
    endfunction

    function automatic t_seg make_seg(input longint c[6]);
        t_seg sg;
        sg.start_x = t_coord'(c[0]); sg.start_y = t_coord'(c[1]);
        sg.start_z = t_coord'(c[2]); sg.end_x = t_coord'(c[3]);
        sg.end_y = t_coord'(c[4]);   sg.end_z = t_coord'(c[5]);
        return sg;
    endfunction

    function automatic t_seg random_seg();
        longint c[6], lo, hi, w;
        int mode;
        mode = $urandom_range(9);
        for (int i = 0; i < 6; i++) begin
            lo = box_lo[i % 3] < box_hi[i % 3] ? box_lo[i % 3] : box_hi[i % 3];
            hi = box_lo[i % 3] < box_hi[i % 3] ? box_hi[i % 3] : box_lo[i % 3];
            w = (hi - lo) / 2 + ONE * $urandom_range(1, 4);
            if (mode < 2)
                c[i] = longint'(t_coord'($urandom));
            else
                c[i] = rnd_between(clamp(lo - w), clamp(hi + w));
        end
        if (mode == 2)
            for (int i = 0; i < 3; i++) c[i + 3] = c[i];
        if (mode == 3) begin
            w = $urandom_range(2);
            c[w + 3 * $urandom_range(1)] = $urandom_range(1) ? box_lo[w] : box_hi[w];
        end
        return make_seg(c);
    endfunction

    task automatic queue_directed();
        longint m[3], c[6];
        for (int a = 0; a < 3; a++) m[a] = (box_lo[a] + box_hi[a]) / 2;
        c = '{m[0], m[1], m[2], m[0], m[1], m[2]};
        seg_pending.push_back(make_seg(c));
        c = '{box_lo[0], m[1], m[2], box_lo[0], m[1], m[2]};
        seg_pending.push_back(make_seg(c));
        c = '{box_lo[0], m[1], m[2], box_hi[0] + ONE, m[1], m[2]};
        seg_pending.push_back(make_seg(c));
        for (int f = 0; f < 6; f++) begin
            int a;
            longint p;
            a = f % 3;
            p = f < 3 ? box_lo[a] : box_hi[a];
            for (int i = 0; i < 3; i++) begin c[i] = m[i]; c[i + 3] = m[i]; end
            c[a] = f < 3 ? p - 2 * ONE : p + 2 * ONE;
            c[a + 3] = f < 3 ? p + ONE : p - ONE;
            seg_pending.push_back(make_seg(c));
            c[a + 3] = f < 3 ? p - ONE : p + ONE;
            seg_pending.push_back(make_seg(c));
        end
        c = '{box_lo[0] - ONE, box_lo[1] - ONE, m[2], box_lo[0] - ONE,
              box_hi[1] + ONE, m[2]};
        seg_pending.push_back(make_seg(c));
        c = '{box_lo[0] - 4 * ONE, box_hi[1] + ONE, m[2], box_lo[0] + ONE,
              box_hi[1] + 4 * ONE, m[2]};
        seg_pending.push_back(make_seg(c));
        c = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX};
        seg_pending.push_back(make_seg(c));
        c = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN};
        seg_pending.push_back(make_seg(c));
        c = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
        seg_pending.push_back(make_seg(c));
        c = '{0, 0, 0, 0, 0, 0};
        seg_pending.push_back(make_seg(c));
        c = '{-1, -1, -1, -1, -1, -1};
        seg_pending.push_back(make_seg(c));
    endtask

    task automatic queue_random(input int n);
        repeat (n) seg_pending.push_back(random_seg());
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input longint v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = COORD_W'(v);
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx < 3'd3)
            box_lo[idx] = longint'(t_coord'(v));
        else if (idx < 3'd6)
            box_hi[idx - 3'd3] = longint'(t_coord'(v));
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_box(input longint lx, ly, lz, hx, hy, hz);
        cfg_write(CFG_MIN_X, lx); cfg_write(CFG_MIN_Y, ly); cfg_write(CFG_MIN_Z, lz);
        cfg_write(CFG_MAX_X, hx); cfg_write(CFG_MAX_Y, hy); cfg_write(CFG_MAX_Z, hz);
    endtask

    task automatic drain();
        while (seg_pending.size() != 0 || i_push || hit_expected.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        n_phases++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            word_taken = i_push && !o_full;
            if (word_taken) begin
                hit_expected.push_back(predict_hit(i_seg));
                n_words++;
            end
            if (i_pop && !o_empty) begin
                if (hit_expected.size() == 0) begin
                    $error("result word with nothing expected");
                    errors++;
                end else begin
                    t_res x;
                    x = hit_expected.pop_front();
                    if (o_res.hits_box !== x.hits_box) begin
                        $error("hits_box expected %0b actual %0b", x.hits_box, o_res.hits_box);
                        errors++;
                    end
                    if (o_res.box_valid !== x.box_valid) begin
                        $error("box_valid expected %0b actual %0b",
                               x.box_valid, o_res.box_valid);
                        errors++;
                    end
                    if (x.hits_box) n_hits++;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_push || word_taken) begin
                if (!send_hold && seg_pending.size() != 0 &&
                    (calm || $urandom_range(99) >= 25)) begin
                    i_seg <= seg_pending.pop_front();
                    i_push <= 1'b1;
                end else begin
                    i_push <= 1'b0;
                end
            end
            i_pop <= !rx_hold && (calm || $urandom_range(99) >= 25);
        end
    end

    always begin
        wait (rx_hold);
        repeat (400) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    initial begin
        #5ms;
        $display("segment_box_intersect: mismatch");
        $finish;
    end

    initial begin
        for (int a = 0; a < 3; a++) begin box_lo[a] = ONE; box_hi[a] = -ONE; end
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        queue_directed();
        queue_random(120);
        drain();

        set_box(-2 * ONE, -2 * ONE, -2 * ONE, 3 * ONE, 3 * ONE, 3 * ONE);
        queue_directed();
        calm = 1'b1;
        queue_random(250);
        drain();
        calm = 1'b0;

        set_box(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        queue_directed();
        queue_random(180);
        drain();

        set_box(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        queue_random(60);
        drain();

        begin
            longint p[3];
            for (int a = 0; a < 3; a++) p[a] = longint'(t_coord'($urandom)) >>> 4;
            set_box(p[0], p[1], p[2], p[0], p[1], p[2]);
            queue_directed();
            queue_random(150);
            drain();
        end

        set_box(-ONE, 5 * ONE, -ONE, ONE, 4 * ONE, ONE);
        cfg_write(CFG_SPARE_A, $urandom);
        cfg_write(CFG_SPARE_B, $urandom);
        queue_random(120);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            longint l[3], h[3];
            for (int a = 0; a < 3; a++) begin
                l[a] = longint'(t_coord'($urandom)) >>> $urandom_range(2, 14);
                h[a] = clamp(l[a] + rnd_between(0, ONE * $urandom_range(1, 200)));
            end
            set_box(l[0], l[1], l[2], h[0], h[1], h[2]);
            if (ph == 1) rx_hold = 1'b1;
            queue_random(80);
            if (ph == 2) begin
                while (seg_pending.size() != 0) @(posedge i_clk);
                send_hold = 1'b1;
                while (i_push || hit_expected.size() != 0) @(posedge i_clk);
                send_hold = 1'b0;
            end
            queue_random(80);
            drain();
        end

        $display("covered %0d segment words over %0d box settings, %0d hits",
                 n_words, n_phases, n_hits);
        if (errors == 0)
            $display("segment_box_intersect: match");
        else
            $display("segment_box_intersect: mismatch");
        $finish;
    end
endmodule

/* files.f */
rtl/sbi_pkg.sv
rtl/sbi_front.sv
rtl/sbi_back.sv
rtl/segment_box_intersect.sv
bench/tb_segment_box_intersect.sv
